// ===== design/i2cms_pkg.sv =====
`timescale 1ns / 1ps

package i2cms_pkg;

  // Request kinds carried in the mode field. Codes 5 to 7 mean nothing.
  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_STATUS = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // Controller status codes.
  localparam logic [7:0] SC_START       = 8'h08;
  localparam logic [7:0] SC_REP_START   = 8'h10;
  localparam logic [7:0] SC_SLAW_ACK    = 8'h18;
  localparam logic [7:0] SC_SLAW_NACK   = 8'h20;
  localparam logic [7:0] SC_TX_ACK      = 8'h28;
  localparam logic [7:0] SC_TX_NACK     = 8'h30;
  localparam logic [7:0] SC_ARB_LOST    = 8'h38;
  localparam logic [7:0] SC_SLAR_ACK    = 8'h40;
  localparam logic [7:0] SC_SLAR_NACK   = 8'h48;
  localparam logic [7:0] SC_RX_ACK      = 8'h50;
  localparam logic [7:0] SC_RX_NACK     = 8'h58;

  localparam logic [23:0] TIMEOUT_RESET = 24'd65535;
  localparam logic [23:0] TICKS_MAX     = 24'hFFFFFF;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_BUSY      = 4'd1,
    ST_OK        = 4'd2,
    ST_NO_DATA   = 4'd3,
    ST_NACK_DATA = 4'd4,
    ST_NACK_ADDR = 4'd5,
    ST_REP_START = 4'd6,
    ST_ARB_LOST  = 4'd7,
    ST_TIMEOUT   = 4'd8
  } xfer_state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [5:0] buf_index;
    logic [7:0] byte_value;
    logic [5:0] write_count;
    logic [6:0] read_count;
    logic [7:0] bus_status;
    logic [7:0] bus_data;
  } item_t;

  typedef struct packed {
    logic [3:0] seq_state;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       request_start;
    logic       request_stop;
    logic       clear_start;
    logic       ack_update;
    logic       ack_next;
    logic       start_accepted;
    logic [7:0] read_byte;
  } result_t;

  typedef struct packed {
    logic tx_we;
    logic rx_we;
  } store_wr_t;

endpackage

// ===== design/i2cms_buf.sv =====
`timescale 1ns / 1ps

// Byte store with one write port and one registered read port. A write to
// the address being read in the same cycle is passed straight to the output.
module i2cms_buf #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

// ===== design/i2cms_step.sv =====
`timescale 1ns / 1ps

// Works out the effect of one request on the sequencer state, and the
// result that goes with it.
module i2cms_step
  import i2cms_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64,
  localparam int IW = $clog2(BUFFER_DEPTH),
  localparam int PW = $clog2(BUFFER_DEPTH + 1)
) (
  input  item_t          item,
  input  xfer_state_t    state,
  input  logic [PW-1:0]  send_pos,
  input  logic [PW-1:0]  recv_pos,
  input  logic [5:0]     write_cnt,
  input  logic [6:0]     read_cnt,
  input  logic [23:0]    idle_ticks,
  input  logic [23:0]    timeout_limit,
  input  logic [7:0]     tx_first,
  input  logic [7:0]     tx_rdata,
  input  logic [7:0]     rx_rdata,
  output xfer_state_t    state_next,
  output logic [PW-1:0]  send_pos_next,
  output logic [PW-1:0]  recv_pos_next,
  output logic [5:0]     write_cnt_next,
  output logic [6:0]     read_cnt_next,
  output logic [23:0]    idle_ticks_next,
  output logic [IW-1:0]  tx_raddr_next,
  output logic [IW-1:0]  tx_waddr,
  output logic [IW-1:0]  rx_waddr,
  output store_wr_t      wr,
  output result_t        res
);

  localparam int XW = ((PW > 7) ? PW : 7) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(BUFFER_DEPTH);
  localparam logic [IW-1:0] LAST    = IW'(BUFFER_DEPTH - 1);

  function automatic logic [IW-1:0] clamp_pos(input logic [XW-1:0] p);
    return (p >= DEPTH_X) ? LAST : p[IW-1:0];
  endfunction

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (XW'(p) < DEPTH_X) ? p + 1'b1 : p;
  endfunction

  logic            active;
  logic            timed_out;
  logic [PW-1:0]   recv_adv;

  assign active    = (state == ST_BUSY) || (state == ST_REP_START);
  assign timed_out = idle_ticks > timeout_limit;
  assign recv_adv  = advance(recv_pos);

  assign tx_waddr      = clamp_pos(XW'(item.buf_index));
  assign rx_waddr      = clamp_pos(XW'(recv_pos));
  assign tx_raddr_next = clamp_pos(XW'(send_pos_next));

  // Transfer state.
  always_comb begin
    state_next = state;
    unique case (item.mode)
      MODE_START: begin
        if ((state == ST_IDLE) || (state == ST_OK)) begin
          state_next = ST_BUSY;
        end
      end
      MODE_STATUS: begin
        unique case (item.bus_status)
          SC_START, SC_REP_START, SC_SLAW_NACK, SC_ARB_LOST,
          SC_SLAR_ACK, SC_RX_ACK: begin
            state_next = state;
          end
          SC_SLAW_ACK: begin
            if (write_cnt == 6'd1) begin
              state_next = ST_NO_DATA;
            end
          end
          SC_TX_ACK: begin
            if (XW'(send_pos) >= XW'(write_cnt)) begin
              state_next = (read_cnt != 7'd0) ? ST_REP_START : ST_OK;
            end
          end
          SC_TX_NACK:   state_next = ST_NACK_DATA;
          SC_SLAR_NACK: state_next = ST_NACK_ADDR;
          SC_RX_NACK:   state_next = ST_OK;
          default:      state_next = ST_ARB_LOST;
        endcase
      end
      MODE_TICK: begin
        if (active && timed_out) begin
          state_next = ST_TIMEOUT;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Positions, counts, store writes and result flags.
  always_comb begin
    send_pos_next   = send_pos;
    recv_pos_next   = recv_pos;
    write_cnt_next  = write_cnt;
    read_cnt_next   = read_cnt;
    idle_ticks_next = idle_ticks;
    wr              = '0;
    res             = '0;
    unique case (item.mode)
      MODE_LOAD: begin
        wr.tx_we = 1'b1;
      end
      MODE_START: begin
        if ((state == ST_IDLE) || (state == ST_OK)) begin
          write_cnt_next     = item.write_count;
          read_cnt_next      = item.read_count;
          idle_ticks_next    = '0;
          res.request_start  = 1'b1;
          res.start_accepted = 1'b1;
        end
      end
      MODE_STATUS: begin
        idle_ticks_next = '0;
        unique case (item.bus_status)
          SC_START: begin
            send_pos_next   = advance('0);
            res.send_valid  = 1'b1;
            res.send_byte   = tx_first;
            res.clear_start = 1'b1;
          end
          SC_REP_START: begin
            recv_pos_next   = '0;
            send_pos_next   = advance(send_pos);
            res.send_valid  = 1'b1;
            res.send_byte   = tx_rdata;
            res.clear_start = 1'b1;
          end
          SC_SLAW_ACK: begin
            if (write_cnt == 6'd1) begin
              res.request_stop = 1'b1;
            end else begin
              send_pos_next  = advance(send_pos);
              res.send_valid = 1'b1;
              res.send_byte  = tx_rdata;
            end
          end
          SC_TX_ACK: begin
            if (XW'(send_pos) < XW'(write_cnt)) begin
              send_pos_next  = advance(send_pos);
              res.send_valid = 1'b1;
              res.send_byte  = tx_rdata;
            end else if (read_cnt != 7'd0) begin
              res.request_start = 1'b1;
            end else begin
              res.request_stop = 1'b1;
            end
          end
          SC_TX_NACK, SC_SLAR_NACK: begin
            res.request_stop = 1'b1;
          end
          SC_SLAR_ACK: begin
            res.ack_update = 1'b1;
            res.ack_next   = (XW'(recv_pos) + XW'(1)) < XW'(read_cnt);
          end
          SC_RX_ACK: begin
            wr.rx_we       = 1'b1;
            recv_pos_next  = recv_adv;
            res.ack_update = 1'b1;
            res.ack_next   = (XW'(recv_adv) + XW'(1)) < XW'(read_cnt);
          end
          SC_RX_NACK: begin
            wr.rx_we         = 1'b1;
            recv_pos_next    = recv_adv;
            res.request_stop = 1'b1;
          end
          default: begin
            res.send_valid = 1'b0;
          end
        endcase
        // Any event that ends a transfer in progress drops the start flag.
        if (active && (state_next != ST_BUSY) && (state_next != ST_REP_START)) begin
          res.clear_start = 1'b1;
        end
      end
      MODE_TICK: begin
        if (active) begin
          if (timed_out) begin
            res.clear_start = 1'b1;
          end else if (idle_ticks != TICKS_MAX) begin
            idle_ticks_next = idle_ticks + 24'd1;
          end
        end
      end
      MODE_READ: begin
        res.read_byte = rx_rdata;
      end
      default: begin
        res.read_byte = '0;
      end
    endcase
    res.seq_state = state_next;
  end

endmodule

// ===== design/i2c_master_transfer_sequencer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Carries
// cfg       in         cfg_we                 timeout_limit (cfg_wdata)
// in        in         in_valid / in_ready    mode, buf_index, byte_value, write_count,
//                                             read_count, bus_status, bus_data
// out       out        out_valid / out_ready  seq_state, send/start/stop/ack flags,
//                                             read_byte
//
// Every request gives exactly one result. It passes through the request register,
// while the store reads are registered, and then through the result register.
// One request is taken each cycle unless out_ready holds the result register full.
// The request register is there because each byte store has a registered read
// port; it adds latency but costs nothing in rate.
// Reset (rst, synchronous) returns the sequencer to idle with both buffer
// positions and all counts at zero; the byte stores are not cleared.
// When out_ready is low the result register holds, the request register
// fills behind it, and in_ready drops until the result is taken.
module i2c_master_transfer_sequencer
  import i2cms_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [5:0]  buf_index,
  input  logic [7:0]  byte_value,
  input  logic [5:0]  write_count,
  input  logic [6:0]  read_count,
  input  logic [7:0]  bus_status,
  input  logic [7:0]  bus_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  seq_state,
  output logic        send_valid,
  output logic [7:0]  send_byte,
  output logic        request_start,
  output logic        request_stop,
  output logic        clear_start,
  output logic        ack_update,
  output logic        ack_next,
  output logic        start_accepted,
  output logic [7:0]  read_byte
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam int PW = $clog2(BUFFER_DEPTH + 1);

  // Request register.
  logic          p_valid;
  item_t         p_item;
  logic          accept;
  logic          adv;

  // Sequencer state.
  xfer_state_t   transfer_state;
  logic [PW-1:0] send_position;
  logic [PW-1:0] receive_position;
  logic [5:0]    bytes_to_write;
  logic [6:0]    bytes_to_read;
  logic [23:0]   idle_ticks;
  logic [23:0]   timeout_limit;
  logic [7:0]    tx_first;
  logic [IW-1:0] tx_raddr;

  // Next values from the step logic.
  xfer_state_t   transfer_state_next;
  logic [PW-1:0] send_position_next;
  logic [PW-1:0] receive_position_next;
  logic [5:0]    bytes_to_write_next;
  logic [6:0]    bytes_to_read_next;
  logic [23:0]   idle_ticks_next;
  logic [IW-1:0] tx_raddr_next;
  logic [IW-1:0] tx_waddr;
  logic [IW-1:0] rx_waddr;
  store_wr_t     wr;
  result_t       step_res;

  // Store ports.
  logic [IW-1:0] tx_rd_addr;
  logic [IW-1:0] rx_rd_addr;
  logic [7:0]    tx_rdata;
  logic [7:0]    rx_rdata;

  result_t       out_res;

  // The request register moves on whenever the result register is free or
  // is being emptied in the same cycle.
  assign adv      = p_valid && (!out_valid || out_ready);
  assign in_ready = !p_valid || adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_item.mode        <= mode;
      p_item.buf_index   <= buf_index;
      p_item.byte_value  <= byte_value;
      p_item.write_count <= write_count;
      p_item.read_count  <= read_count;
      p_item.bus_status  <= bus_status;
      p_item.bus_data    <= bus_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_limit <= cfg_wdata;
    end
  end

  // The transmit store is read every cycle at the send position that will
  // hold after this edge, so its read data always matches the state.
  assign tx_rd_addr = adv ? tx_raddr_next : tx_raddr;

  // The receive store is read for the request as it enters the register.
  assign rx_rd_addr = (int'(buf_index) >= BUFFER_DEPTH) ? IW'(BUFFER_DEPTH - 1)
                                                         : IW'(buf_index);

  i2cms_buf #(
    .DEPTH (BUFFER_DEPTH)
  ) u_tx_buf (
    .clk   (clk),
    .we    (adv && wr.tx_we),
    .waddr (tx_waddr),
    .wdata (p_item.byte_value),
    .re    (1'b1),
    .raddr (tx_rd_addr),
    .rdata (tx_rdata)
  );

  i2cms_buf #(
    .DEPTH (BUFFER_DEPTH)
  ) u_rx_buf (
    .clk   (clk),
    .we    (adv && wr.rx_we),
    .waddr (rx_waddr),
    .wdata (p_item.bus_data),
    .re    (accept),
    .raddr (rx_rd_addr),
    .rdata (rx_rdata)
  );

  // The start event always sends the address byte, so a copy of entry zero
  // is kept beside the store.
  always_ff @(posedge clk) begin
    if (adv && wr.tx_we && (tx_waddr == '0)) begin
      tx_first <= p_item.byte_value;
    end
  end

  i2cms_step #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_step (
    .item            (p_item),
    .state           (transfer_state),
    .send_pos        (send_position),
    .recv_pos        (receive_position),
    .write_cnt       (bytes_to_write),
    .read_cnt        (bytes_to_read),
    .idle_ticks      (idle_ticks),
    .timeout_limit   (timeout_limit),
    .tx_first        (tx_first),
    .tx_rdata        (tx_rdata),
    .rx_rdata        (rx_rdata),
    .state_next      (transfer_state_next),
    .send_pos_next   (send_position_next),
    .recv_pos_next   (receive_position_next),
    .write_cnt_next  (bytes_to_write_next),
    .read_cnt_next   (bytes_to_read_next),
    .idle_ticks_next (idle_ticks_next),
    .tx_raddr_next   (tx_raddr_next),
    .tx_waddr        (tx_waddr),
    .rx_waddr        (rx_waddr),
    .wr              (wr),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_state   <= ST_IDLE;
      send_position    <= '0;
      receive_position <= '0;
      bytes_to_write   <= '0;
      bytes_to_read    <= '0;
      idle_ticks       <= '0;
      tx_raddr         <= '0;
    end else if (adv) begin
      transfer_state   <= transfer_state_next;
      send_position    <= send_position_next;
      receive_position <= receive_position_next;
      bytes_to_write   <= bytes_to_write_next;
      bytes_to_read    <= bytes_to_read_next;
      idle_ticks       <= idle_ticks_next;
      tx_raddr         <= tx_raddr_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= step_res;
    end
  end

  assign seq_state      = out_res.seq_state;
  assign send_valid     = out_res.send_valid;
  assign send_byte      = out_res.send_byte;
  assign request_start  = out_res.request_start;
  assign request_stop   = out_res.request_stop;
  assign clear_start    = out_res.clear_start;
  assign ack_update     = out_res.ack_update;
  assign ack_next       = out_res.ack_next;
  assign start_accepted = out_res.start_accepted;
  assign read_byte      = out_res.read_byte;

  // Buffer positions saturate at the depth and never run past it.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (int'(send_position) <= BUFFER_DEPTH) && (int'(receive_position) <= BUFFER_DEPTH))
    else $error("buffer position beyond depth");

  // A start is only taken from idle or from a finished transfer.
  a_start_from_rest: assert property (@(posedge clk) disable iff (rst)
    (adv && step_res.start_accepted) |->
      ((transfer_state == ST_IDLE) || (transfer_state == ST_OK)))
    else $error("start accepted during a transfer");

  // A stalled request keeps its place and its contents.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !adv) |=> (p_valid && $stable(p_item)))
    else $error("stalled request lost or changed");

  // The sequencer state moves only when a request is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(transfer_state) && $stable(send_position) && $stable(idle_ticks)))
    else $error("state changed without a request");

  // Any status event restarts the timeout count.
  a_status_clears_ticks: assert property (@(posedge clk) disable iff (rst)
    (adv && (p_item.mode == MODE_STATUS)) |=> (idle_ticks == '0))
    else $error("tick count not cleared by status event");

endmodule
